// File: rtl/twpd_pkg.sv
`timescale 1ns / 1ps

package twpd_pkg;

  localparam int unsigned SECTOR_COUNT_DEF = 32;

  localparam int COUNT_W   = 16;
  localparam int MARGIN_W  = 8;
  localparam int SECTOR_W  = 5;
  localparam int VEC_W     = COUNT_W + 1;
  localparam int BND_W     = 32;
  localparam int PROD_W    = VEC_W + BND_W;
  localparam int CFG_IDX_W = 3;
  localparam int RING_W    = COUNT_W + 2;
  localparam int ALL_W     = COUNT_W + 3;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_BASE  = 3'd0,
    REG_UP_BASE      = 3'd1,
    REG_DOWN_BASE    = 3'd2,
    REG_LEFT_BASE    = 3'd3,
    REG_RIGHT_BASE   = 3'd4,
    REG_TOUCH_MARGIN = 3'd5
  } cfg_reg_t;

  // Q30 fixed point, used only to build the sector boundary table
  localparam logic [63:0] Q_ONE       = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [63:0] SIN_DIV [7] = '{64'd210, 64'd156, 64'd110, 64'd72,
                                          64'd42, 64'd20, 64'd6};
  localparam logic [63:0] COS_DIV [8] = '{64'd240, 64'd182, 64'd132, 64'd90,
                                          64'd56, 64'd30, 64'd12, 64'd2};

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] c;
  } sincos_t;

  // truncating Horner evaluation of the Taylor series, 0 <= x < pi/2
  function automatic sincos_t q30_sincos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    sincos_t     res;
    x2 = (x * x) >> 30;
    t  = Q_ONE;
    for (int i = 0; i < 7; i++) begin
      sub = ((x2 * t) >> 30) / SIN_DIV[i];
      t   = (sub > Q_ONE) ? 64'd0 : Q_ONE - sub;
    end
    res.s = (x * t) >> 30;
    t = Q_ONE;
    for (int i = 0; i < 8; i++) begin
      sub = ((x2 * t) >> 30) / COS_DIV[i];
      t   = (sub > Q_ONE) ? 64'd0 : Q_ONE - sub;
    end
    res.c = t;
    return res;
  endfunction

endpackage

// File: rtl/twpd_sector.sv
`timescale 1ns / 1ps

module twpd_sector #(
  parameter int unsigned SECTOR_COUNT = twpd_pkg::SECTOR_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [twpd_pkg::VEC_W-1:0]    vx,
  input  logic signed [twpd_pkg::VEC_W-1:0]    vy,
  output logic                                 done,
  output logic        [twpd_pkg::SECTOR_W-1:0] sector
);
  import twpd_pkg::*;

  localparam int IW = $clog2(SECTOR_COUNT);
  localparam logic [IW-1:0] LAST     = IW'(SECTOR_COUNT - 1);
  localparam logic [IW-1:0] SEC_EAST = IW'((SECTOR_COUNT + 3) / 4 - 1);
  localparam logic [IW-1:0] SEC_WEST = IW'((3 * SECTOR_COUNT) / 4);

  typedef struct packed {
    logic signed [BND_W-1:0] bx;
    logic signed [BND_W-1:0] by;
    logic                    hb;   // boundary lies in the second half turn
  } bnd_t;

  typedef bnd_t [SECTOR_COUNT-1:0] bnd_tab_t;

  function automatic bnd_tab_t build_tab();
    bnd_tab_t                tab;
    sincos_t                 sc;
    logic [63:0]             s;
    logic [63:0]             c;
    int unsigned             q;
    int unsigned             r;
    logic signed [BND_W-1:0] bx;
    logic signed [BND_W-1:0] by;
    for (int unsigned k = 0; k < SECTOR_COUNT; k++) begin
      q  = (4 * k) / SECTOR_COUNT;
      r  = 4 * k - q * SECTOR_COUNT;
      sc = q30_sincos((HALF_PI_Q30 * 64'(r)) / SECTOR_COUNT);
      s  = sc.s;
      c  = sc.c;
      if (2 * r == SECTOR_COUNT) s = c;
      unique case (q[1:0])
        2'd0: begin
          bx = $signed(BND_W'(s));
          by = $signed(BND_W'(c));
        end
        2'd1: begin
          bx = $signed(BND_W'(c));
          by = -$signed(BND_W'(s));
        end
        2'd2: begin
          bx = -$signed(BND_W'(s));
          by = -$signed(BND_W'(c));
        end
        default: begin
          bx = -$signed(BND_W'(c));
          by = $signed(BND_W'(s));
        end
      endcase
      tab[k].bx = bx;
      tab[k].by = by;
      tab[k].hb = !(bx > 0 || (bx == 0 && by > 0));
    end
    return tab;
  endfunction

  localparam bnd_tab_t BND = build_tab();

  typedef enum logic [1:0] {S_IDLE, S_MA, S_MB, S_CMP} state_t;

  state_t                  state_r;
  logic [IW-1:0]           lo_r, hi_r;
  logic signed [VEC_W-1:0] vx_r, vy_r;
  logic                    hv_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic                    done_r;
  logic [SECTOR_W-1:0]     sector_r;

  logic [IW:0]              mid_sum;
  logic [IW-1:0]            mid;
  bnd_t                     bnd;
  logic signed [VEC_W-1:0]  mul_a;
  logic signed [BND_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     past;
  logic [IW-1:0]            lo_nxt, hi_nxt;
  logic                     done_nxt;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (IW+1)'(1);
  assign mid     = mid_sum[IW:1];
  assign bnd     = BND[mid];

  // one shared multiplier: x*by in the first pass, y*bx in the second
  assign mul_a = (state_r == S_MA) ? vx_r   : vy_r;
  assign mul_b = (state_r == S_MA) ? bnd.by : bnd.bx;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign past = (hv_r != bnd.hb) ? (hv_r && !bnd.hb) : (pa_r >= pb_r);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (past) lo_nxt = mid;
    else      hi_nxt = mid - IW'(1);
  end

  // zero and horizontal vectors finish at once, others when the search closes
  assign done_nxt = ((state_r == S_IDLE) && start && (vy == 0)) ||
                    ((state_r == S_CMP) && !(lo_nxt < hi_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= done_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            vx_r <= vx;
            vy_r <= vy;
            hv_r <= !(vx > 0 || (vx == 0 && vy > 0));
            lo_r <= '0;
            hi_r <= LAST;
            if (vx == 0 && vy == 0) begin
              sector_r <= '0;
            end else if (vy == 0) begin
              // east reads just under a quarter turn, west just over three quarters
              sector_r <= SECTOR_W'((vx > 0) ? SEC_EAST : SEC_WEST);
            end else begin
              state_r <= S_MA;
            end
          end
        end
        S_MA: begin
          pa_r    <= prod;
          state_r <= S_MB;
        end
        S_MB: begin
          pb_r    <= prod;
          state_r <= S_CMP;
        end
        S_CMP: begin
          lo_r <= lo_nxt;
          hi_r <= hi_nxt;
          if (lo_nxt < hi_nxt) begin
            state_r <= S_MA;
          end else begin
            sector_r <= SECTOR_W'(lo_nxt);
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign sector = sector_r;

endmodule

// File: rtl/touch_wheel_position_decoder_top.sv
`timescale 1ns / 1ps

// Five-pad touch wheel decoder.
// Input channel: one scan word (center/up/down/left/right counts), taken when
// in_valid is high and in_stall low. Output channel: one result word per scan
// with the pad flags, ring/any flags, center display and wheel sector, taken
// when out_valid is high and out_stall low.
// Config channel: cfg_ready is always high; cfg_index selects the baseline or
// margin register, cfg_data carries the value (margin uses the low 8 bits).
// Write config only while no scan is in flight.
// Flow: flag math in the PREP and FLAG states, then a binary search over the
// sector boundaries on one shared multiplier, up to ceil(log2(SECTOR_COUNT))
// steps of MA, MB and CMP, then WAIT and OUT to the output register. A zero
// or horizontal vector skips the search. in_stall stays high from acceptance
// until the word is loaded into the output register and drops in the same
// cycle that out_valid rises, so a new scan is taken only once that is done.
// A finished word waits in the output register while out_stall is high; the
// next scan may already be accepted and held until the register frees up.
// Reset clears the ring latch, baselines to 0 and margin to 8.
module touch_wheel_position_decoder_top #(
  parameter int unsigned SECTOR_COUNT = twpd_pkg::SECTOR_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [twpd_pkg::COUNT_W-1:0]          in_center_count,
  input  logic [twpd_pkg::COUNT_W-1:0]          in_up_count,
  input  logic [twpd_pkg::COUNT_W-1:0]          in_down_count,
  input  logic [twpd_pkg::COUNT_W-1:0]          in_left_count,
  input  logic [twpd_pkg::COUNT_W-1:0]          in_right_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_center_touched,
  output logic                                  out_up_touched,
  output logic                                  out_down_touched,
  output logic                                  out_left_touched,
  output logic                                  out_right_touched,
  output logic                                  out_ring_touched,
  output logic                                  out_any_touched,
  output logic                                  out_center_display,
  output logic [twpd_pkg::SECTOR_W-1:0]         out_wheel_sector,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [twpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [twpd_pkg::COUNT_W-1:0]          cfg_data
);
  import twpd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_FLAG, S_WAIT, S_OUT} state_t;

  state_t                state_r;
  logic [COUNT_W-1:0]    cb_r, ub_r, db_r, lb_r, rb_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [COUNT_W-1:0]    cc_r, uc_r, dc_r, lc_r, rc_r;
  logic                  ck_r, uk_r, dk_r, lk_r, rk_r;
  logic                  ring_r, any_r;
  logic [RING_W-1:0]     ring_base_r, ring_cnt_r;
  logic signed [VEC_W-1:0] vx_r, vy_r;
  logic                  latch_r;

  logic                  out_valid_r;
  logic                  o_ck_r, o_uk_r, o_dk_r, o_lk_r, o_rk_r;
  logic                  o_ring_r, o_any_r, o_disp_r;
  logic [SECTOR_W-1:0]   o_sector_r;

  logic [COUNT_W-1:0]    ex_u, ex_d, ex_l, ex_r;
  logic                  sec_start, sec_done;
  logic [SECTOR_W-1:0]   sec_val;
  logic                  out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign sec_start = (state_r == S_FLAG);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign ex_u = (uc_r > ub_r) ? uc_r - ub_r : '0;
  assign ex_d = (dc_r > db_r) ? dc_r - db_r : '0;
  assign ex_l = (lc_r > lb_r) ? lc_r - lb_r : '0;
  assign ex_r = (rc_r > rb_r) ? rc_r - rb_r : '0;

  twpd_sector #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_sector (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sec_start),
    .vx     (vx_r),
    .vy     (vy_r),
    .done   (sec_done),
    .sector (sec_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r     <= '0;
      ub_r     <= '0;
      db_r     <= '0;
      lb_r     <= '0;
      rb_r     <= '0;
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_BASE:  cb_r     <= cfg_data;
        REG_UP_BASE:      ub_r     <= cfg_data;
        REG_DOWN_BASE:    db_r     <= cfg_data;
        REG_LEFT_BASE:    lb_r     <= cfg_data;
        REG_RIGHT_BASE:   rb_r     <= cfg_data;
        REG_TOUCH_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cc_r    <= in_center_count;
            uc_r    <= in_up_count;
            dc_r    <= in_down_count;
            lc_r    <= in_left_count;
            rc_r    <= in_right_count;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          ck_r <= ({1'b0, cb_r} + (COUNT_W+1)'(margin_r)) < {1'b0, cc_r};
          uk_r <= ({1'b0, ub_r} + (COUNT_W+1)'(margin_r)) < {1'b0, uc_r};
          dk_r <= ({1'b0, db_r} + (COUNT_W+1)'(margin_r)) < {1'b0, dc_r};
          lk_r <= ({1'b0, lb_r} + (COUNT_W+1)'(margin_r)) < {1'b0, lc_r};
          rk_r <= ({1'b0, rb_r} + (COUNT_W+1)'(margin_r)) < {1'b0, rc_r};
          ring_base_r <= RING_W'(ub_r) + RING_W'(db_r) + RING_W'(lb_r) + RING_W'(rb_r);
          ring_cnt_r  <= RING_W'(uc_r) + RING_W'(dc_r) + RING_W'(lc_r) + RING_W'(rc_r);
          vx_r    <= $signed({1'b0, ex_r}) - $signed({1'b0, ex_l});
          vy_r    <= $signed({1'b0, ex_u}) - $signed({1'b0, ex_d});
          state_r <= S_FLAG;
        end
        S_FLAG: begin
          ring_r  <= (ALL_W'(ring_base_r) + ALL_W'(margin_r)) < ALL_W'(ring_cnt_r);
          any_r   <= (ALL_W'(ring_base_r) + ALL_W'(cb_r) + ALL_W'(margin_r))
                     < (ALL_W'(ring_cnt_r) + ALL_W'(cc_r));
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (sec_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            o_ck_r      <= ck_r;
            o_uk_r      <= uk_r;
            o_dk_r      <= dk_r;
            o_lk_r      <= lk_r;
            o_rk_r      <= rk_r;
            o_ring_r    <= ring_r;
            o_any_r     <= any_r;
            o_sector_r  <= sec_val;
            // display uses the latch as it stood before this scan
            o_disp_r    <= ck_r && !latch_r;
            if (!latch_r) begin
              if (ring_r) latch_r <= 1'b1;
            end else if (!any_r) begin
              latch_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_center_touched = o_ck_r;
  assign out_up_touched     = o_uk_r;
  assign out_down_touched   = o_dk_r;
  assign out_left_touched   = o_lk_r;
  assign out_right_touched  = o_rk_r;
  assign out_ring_touched   = o_ring_r;
  assign out_any_touched    = o_any_r;
  assign out_center_display = o_disp_r;
  assign out_wheel_sector   = o_sector_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("scan accepted but block not busy");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sec_done |-> state_r == S_WAIT)
    else $error("sector search finished outside wait state");

  a_display_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_center_display || out_center_touched))
    else $error("center display without center touch");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import twpd_pkg::*;

  localparam int unsigned SECTORS = SECTOR_COUNT_DEF;
  localparam longint unsigned Q30_UNIT = 64'd1 << 30;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0] center;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W-1:0] down;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] right;
  } scan_t;

  typedef struct packed {
    logic                center_key;
    logic                up_key;
    logic                down_key;
    logic                left_key;
    logic                right_key;
    logic                ring_key;
    logic                any_key;
    logic                center_disp;
    logic [SECTOR_W-1:0] sector;
  } wheel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COUNT_W-1:0] in_center_count = '0;
  logic [COUNT_W-1:0] in_up_count = '0;
  logic [COUNT_W-1:0] in_down_count = '0;
  logic [COUNT_W-1:0] in_left_count = '0;
  logic [COUNT_W-1:0] in_right_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_center_touched;
  logic out_up_touched;
  logic out_down_touched;
  logic out_left_touched;
  logic out_right_touched;
  logic out_ring_touched;
  logic out_any_touched;
  logic out_center_display;
  logic [SECTOR_W-1:0] out_wheel_sector;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;

  touch_wheel_position_decoder_top #(
    .SECTOR_COUNT(SECTORS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_center_count   (in_center_count),
    .in_up_count       (in_up_count),
    .in_down_count     (in_down_count),
    .in_left_count     (in_left_count),
    .in_right_count    (in_right_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_center_touched(out_center_touched),
    .out_up_touched    (out_up_touched),
    .out_down_touched  (out_down_touched),
    .out_left_touched  (out_left_touched),
    .out_right_touched (out_right_touched),
    .out_ring_touched  (out_ring_touched),
    .out_any_touched   (out_any_touched),
    .out_center_display(out_center_display),
    .out_wheel_sector  (out_wheel_sector),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // shadow of the block's registers and latch
  logic [COUNT_W-1:0]  pad_base [5];
  logic [MARGIN_W-1:0] touch_margin;
  logic                ring_latch;

  // sector boundary directions, Q30
  longint bnd_x [SECTORS];
  longint bnd_y [SECTORS];
  bit     bnd_half [SECTORS];

  wheel_word_t predicted_words [$];
  int          mismatch_count = 0;
  int          word_count = 0;
  bit          idle_on = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: reports a mismatch if the 1666 words with stalls do not finish in time
  initial begin
    #10_000_000;
    $display("touch_wheel_position_decoder_top: mismatch");
    $finish;
  end

  initial begin : boundary_table
    longint unsigned ang, x2, t, sub, sn, cs;
    int q, r;
    for (int k = 0; k < SECTORS; k++) begin
      q = (4 * k) / SECTORS;
      r = 4 * k - q * SECTORS;
      ang = (QUARTER_TURN_Q30 * r) / SECTORS;
      x2 = (ang * ang) >> 30;
      // truncating Horner steps of the Taylor series
      t = Q30_UNIT;
      for (int n = 7; n >= 1; n--) begin
        sub = ((x2 * t) >> 30) / longint'((2 * n) * (2 * n + 1));
        t = (sub > Q30_UNIT) ? 64'd0 : Q30_UNIT - sub;
      end
      sn = (ang * t) >> 30;
      t = Q30_UNIT;
      for (int n = 8; n >= 1; n--) begin
        sub = ((x2 * t) >> 30) / longint'((2 * n - 1) * (2 * n));
        t = (sub > Q30_UNIT) ? 64'd0 : Q30_UNIT - sub;
      end
      cs = t;
      if (2 * r == SECTORS) sn = cs;
      case (q & 3)
        0: begin
          bnd_x[k] = longint'(sn);
          bnd_y[k] = longint'(cs);
        end
        1: begin
          bnd_x[k] = longint'(cs);
          bnd_y[k] = -longint'(sn);
        end
        2: begin
          bnd_x[k] = -longint'(sn);
          bnd_y[k] = -longint'(cs);
        end
        default: begin
          bnd_x[k] = -longint'(cs);
          bnd_y[k] = longint'(sn);
        end
      endcase
      bnd_half[k] = (bnd_x[k] > 0 || (bnd_x[k] == 0 && bnd_y[k] > 0)) ? 1'b0 : 1'b1;
    end
  end

  function automatic int unsigned pad_excess(input int unsigned cnt, input int unsigned base);
    return (cnt > base) ? cnt - base : 0;
  endfunction

  // expected word for one scan; advances the ring latch
  function automatic wheel_word_t decode_scan(input scan_t s);
    int unsigned bc, bu, bd, bl, br, m, ring_base, ring_sum;
    longint vx, vy;
    int lo, hi, mid;
    bit v_half, past;
    wheel_word_t w;
    bc = pad_base[REG_CENTER_BASE];
    bu = pad_base[REG_UP_BASE];
    bd = pad_base[REG_DOWN_BASE];
    bl = pad_base[REG_LEFT_BASE];
    br = pad_base[REG_RIGHT_BASE];
    m = touch_margin;
    w.center_key = bc + m < s.center;
    w.up_key = bu + m < s.up;
    w.down_key = bd + m < s.down;
    w.left_key = bl + m < s.left;
    w.right_key = br + m < s.right;
    ring_base = bu + bd + bl + br;
    ring_sum = s.up + s.down + s.left + s.right;
    w.ring_key = ring_base + m < ring_sum;
    w.any_key = ring_base + bc + m < ring_sum + s.center;
    vx = longint'(pad_excess(s.right, br)) - longint'(pad_excess(s.left, bl));
    vy = longint'(pad_excess(s.up, bu)) - longint'(pad_excess(s.down, bd));
    if (vx == 0 && vy == 0) begin
      lo = 0;
    end else if (vy == 0) begin
      // horizontal: just under a quarter turn, or just over three quarters
      lo = (vx > 0) ? (SECTORS + 3) / 4 - 1 : (3 * SECTORS) / 4;
    end else begin
      v_half = (vx > 0 || (vx == 0 && vy > 0)) ? 1'b0 : 1'b1;
      lo = 0;
      hi = SECTORS - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (v_half != bnd_half[mid]) past = v_half > bnd_half[mid];
        else past = (vx * bnd_y[mid] - vy * bnd_x[mid]) >= 0;
        if (past) lo = mid;
        else hi = mid - 1;
      end
    end
    w.sector = lo[SECTOR_W-1:0];
    if (!ring_latch) begin
      w.center_disp = w.center_key;
      if (w.ring_key) ring_latch = 1'b1;
    end else begin
      w.center_disp = 1'b0;
      if (!w.any_key) ring_latch = 1'b0;
    end
    return w;
  endfunction

  // realistic scans around the baselines, some pure noise
  function automatic scan_t make_scan();
    int d [5];
    logic [COUNT_W-1:0] cnt [5];
    int v, kind;
    bit tiny;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    end
    tiny = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 5; i++) d[i] = int'($urandom_range(0, 40)) - 20;
    if (kind >= 40 && kind < 85) begin
      for (int i = 1; i < 5; i++) begin
        if ($urandom_range(0, 1) == 1)
          d[i] = tiny ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 3000));
      end
    end
    if (kind >= 70) d[0] = int'($urandom_range(0, 800));
    // equal up/down pull gives a horizontal vector
    if ($urandom_range(0, 7) == 0) d[2] = d[1];
    for (int i = 0; i < 5; i++) begin
      v = int'(pad_base[i]) + d[i];
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      cnt[i] = v[COUNT_W-1:0];
    end
    return {cnt[0], cnt[1], cnt[2], cnt[3], cnt[4]};
  endfunction

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 25);
  end

  // sampled mid-cycle: a word seen here is taken at the next rising edge
  always @(negedge clk) begin : check_words
    wheel_word_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_center_touched, out_up_touched, out_down_touched, out_left_touched,
             out_right_touched, out_ring_touched, out_any_touched, out_center_display,
             out_wheel_sector};
      word_count++;
      if (predicted_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: word %0d arrived with none pending: %h", $time, word_count, got);
      end else begin
        want = predicted_words.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: word %0d expected c%b u%b d%b l%b r%b ring%b any%b disp%b sec%0d",
                     $time, word_count, want.center_key, want.up_key, want.down_key,
                     want.left_key, want.right_key, want.ring_key, want.any_key,
                     want.center_disp, want.sector);
            $display("%0t: word %0d got      c%b u%b d%b l%b r%b ring%b any%b disp%b sec%0d",
                     $time, word_count, got.center_key, got.up_key, got.down_key,
                     got.left_key, got.right_key, got.ring_key, got.any_key,
                     got.center_disp, got.sector);
          end
        end
      end
    end
  end

  task automatic send_scan(input scan_t s);
    bit taken;
    if (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      {in_center_count, in_up_count, in_down_count, in_left_count, in_right_count} <=
        {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < 25);
    end
    in_valid <= 1'b1;
    {in_center_count, in_up_count, in_down_count, in_left_count, in_right_count} <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!in_stall) begin
        taken = 1'b1;
        predicted_words.push_back(decode_scan(s));
      end
      @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  // caller makes sure no scan is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (cfg_ready) begin
        taken = 1'b1;
        case (idx)
          REG_CENTER_BASE, REG_UP_BASE, REG_DOWN_BASE, REG_LEFT_BASE, REG_RIGHT_BASE:
            pad_base[idx] = data;
          REG_TOUCH_MARGIN: touch_margin = data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset settings: baselines 0, margin 8
  task automatic test_directed_scans();
    send_scan({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_scan({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'd9, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'd8, 16'd8, 16'd0, 16'd0, 16'd0});
    // ring touch sets the latch, center is blanked until full release
    send_scan({16'd0, 16'd100, 16'd0, 16'd0, 16'd0});
    send_scan({16'd100, 16'd0, 16'd0, 16'd0, 16'd100});
    send_scan({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'd100, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'd0, 16'd0, 16'd0, 16'd100, 16'd0});
    send_scan({16'd0, 16'd0, 16'd100, 16'd0, 16'd0});
    // diagonals land exactly on boundaries
    send_scan({16'd0, 16'd100, 16'd0, 16'd0, 16'd100});
    send_scan({16'd0, 16'd0, 16'd100, 16'd100, 16'd0});
    send_scan({16'd0, 16'd1, 16'd0, 16'd1, 16'd0});
    // up equals down: horizontal either way
    send_scan({16'd0, 16'd50, 16'd50, 16'd0, 16'd60});
    send_scan({16'd0, 16'd50, 16'd50, 16'd60, 16'd0});
    send_scan({16'd0, 16'd3, 16'd0, 16'd0, 16'd1});
    send_scan({16'h0000, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA});
    send_scan({16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555});
  endtask

  task automatic test_extreme_settings();
    wait_results_done();
    for (int i = 0; i < 5; i++) write_reg(cfg_reg_t'(i), 16'hFFFF);
    write_reg(REG_TOUCH_MARGIN, 16'hFFFF);
    write_reg(REG_UNMAPPED_6, 16'h0000);
    write_reg(REG_UNMAPPED_7, 16'h0000);
    send_scan({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_scan({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_scan({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    wait_results_done();
    for (int i = 0; i < 5; i++) write_reg(cfg_reg_t'(i), 16'h0000);
    // upper byte of the margin word is dropped
    write_reg(REG_TOUCH_MARGIN, 16'hFF00);
    write_reg(REG_UNMAPPED_7, 16'hFFFF);
    send_scan({16'd1, 16'd1, 16'd0, 16'd0, 16'd0});
    send_scan({16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
    send_scan({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_scan({16'd0, 16'd0, 16'd0, 16'd1, 16'd0});
  endtask

  task automatic test_random_scans();
    for (int phase = 0; phase < 4; phase++) begin
      wait_results_done();
      for (int i = 0; i < 5; i++)
        write_reg(cfg_reg_t'(i), (phase == 3) ? 16'($urandom_range(0, 400)) : 16'($urandom));
      case (phase)
        1: write_reg(REG_TOUCH_MARGIN, {8'($urandom), 8'h00});
        2: write_reg(REG_TOUCH_MARGIN, {8'($urandom), 8'hFF});
        default: write_reg(REG_TOUCH_MARGIN, 16'($urandom));
      endcase
      write_reg(($urandom_range(0, 1) == 1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7, 16'($urandom));
      // one phase runs back to back on both sides
      idle_on = (phase != 2);
      repeat (410) send_scan(make_scan());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 5; i++) pad_base[i] = '0;
    touch_margin = MARGIN_RESET;
    ring_latch = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_scans();
    test_extreme_settings();
    test_random_scans();
    wait_results_done();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && predicted_words.size() == 0) begin
      $display("touch_wheel_position_decoder_top: match");
    end else begin
      $display("touch_wheel_position_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
